[hdl/gen_pkg.sv]
// Types and constants shared by the grid error norms block.
// gen_front, gen_fifo, gen_back, the top level, the checker and the testbench import it; it depends on nothing.
`default_nettype none

package gen_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned ABS_W     = 32;
  localparam int unsigned NORM_W    = 48;
  localparam int unsigned SUM_W     = 64;
  // Twice the sum of the leading squares plus the last square.
  localparam int unsigned A2_W      = SUM_W + 3;
  localparam int unsigned DIV_NUM_W = A2_W;
  localparam int unsigned DIV_DEN_W = COUNT_W + 1;
  localparam int unsigned PROD_W    = SUM_W + COUNT_W;
  localparam int unsigned RAD_W     = PROD_W + 1;
  localparam int unsigned ROOT_W    = RAD_W / 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(65536);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_value;
    logic signed [SAMPLE_W-1:0] second_value;
    logic                       last_point;
  } gen_in_t;

  typedef struct packed {
    logic [ABS_W-1:0]  max_abs_error;
    logic [NORM_W-1:0] l2_error;
    logic [NORM_W-1:0] w21_error;
  } gen_out_t;

  // Totals of one finished run, handed from the accumulator to the norm engine.
  typedef struct packed {
    logic [ABS_W-1:0]   max_abs;
    logic [SUM_W-1:0]   l2_sum;
    logic [SUM_W:0]     part_sum;
    logic [SUM_W-1:0]   last_square;
    logic [SUM_W-1:0]   nbr_sum;
    logic [COUNT_W-1:0] count;
  } gen_run_t;

endpackage

`default_nettype wire

[hdl/gen_front.sv]
// Sample front end: error forming, squaring pipeline and run accumulators.
// Uses gen_pkg; emits one gen_run_t record per finished run.
`default_nettype none

module gen_front
  import gen_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire gen_in_t            in_data_i,
  input  wire logic [COUNT_W-1:0] point_count_i,
  output logic                    run_push_o,
  output gen_run_t                run_o,
  input  wire logic               run_full_i
);

  logic [SAMPLE_W:0]   d_wide;
  logic [SAMPLE_W-1:0] d_sat;
  logic [SAMPLE_W-1:0] d_mag;
  logic [SAMPLE_W:0]   nb_wide;
  logic [SAMPLE_W:0]   nb_mag;
  logic                accept;
  logic                stall;
  logic                advance;

  logic [SAMPLE_W-1:0] prev_q;
  logic                seen_q;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_mag_q;
  logic [SAMPLE_W-1:0] s1_nb_q;
  logic                s1_first_q;
  logic                s1_last_q;

  logic                s2_valid_q;
  logic [SUM_W-1:0]    s2_sq_q;
  logic [SUM_W-1:0]    s2_nbsq_q;
  logic [ABS_W-1:0]    s2_abs_q;
  logic                s2_first_q;
  logic                s2_last_q;

  logic [ABS_W-1:0]    max_q;
  logic [SUM_W-1:0]    ssum_q;
  logic [SUM_W-1:0]    fsq_q;
  logic [SUM_W-1:0]    nss_q;

  logic [SUM_W:0]      ssum_wide;
  logic [SUM_W:0]      nss_wide;
  logic [SUM_W-1:0]    ssum_sat;
  logic [SUM_W-1:0]    nss_sat;
  logic [ABS_W-1:0]    max_new;
  logic [COUNT_W-1:0]  count_clamped;

  // The difference is formed one bit wider and saturated back to the sample range.
  assign d_wide = {in_data_i.second_value[SAMPLE_W-1], in_data_i.second_value}
                - {in_data_i.first_value[SAMPLE_W-1], in_data_i.first_value};

  always_comb begin
    if (d_wide[SAMPLE_W] != d_wide[SAMPLE_W-1]) begin
      d_sat = d_wide[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      d_sat = d_wide[SAMPLE_W-1:0];
    end
  end

  assign d_mag   = d_sat[SAMPLE_W-1] ? (~d_sat + 1'b1) : d_sat;
  assign nb_wide = {d_sat[SAMPLE_W-1], d_sat} - {prev_q[SAMPLE_W-1], prev_q};
  assign nb_mag  = nb_wide[SAMPLE_W] ? (~nb_wide + 1'b1) : nb_wide;

  // Only a finished run blocked by a full run queue holds the pipeline.
  assign stall   = s2_valid_q && s2_last_q && run_full_i;
  assign advance = !stall;
  assign full    = stall;
  assign accept  = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (accept) begin
        seen_q <= !in_data_i.last_point;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (accept) begin
        prev_q     <= d_sat;
        s1_mag_q   <= d_mag;
        s1_nb_q    <= nb_mag[SAMPLE_W-1:0];
        s1_first_q <= !seen_q;
        s1_last_q  <= in_data_i.last_point;
      end
      s2_sq_q    <= SUM_W'(s1_mag_q * s1_mag_q);
      s2_nbsq_q  <= SUM_W'(s1_nb_q * s1_nb_q);
      s2_abs_q   <= ABS_W'(s1_mag_q);
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  assign ssum_wide = {1'b0, ssum_q} + {1'b0, s2_sq_q};
  assign nss_wide  = {1'b0, nss_q} + {1'b0, s2_nbsq_q};
  assign ssum_sat  = ssum_wide[SUM_W] ? {SUM_W{1'b1}} : ssum_wide[SUM_W-1:0];
  assign nss_sat   = nss_wide[SUM_W] ? {SUM_W{1'b1}} : nss_wide[SUM_W-1:0];
  assign max_new   = (s2_first_q || s2_abs_q > max_q) ? s2_abs_q : max_q;

  always_comb begin
    if (point_count_i < COUNT_MIN) begin
      count_clamped = COUNT_MIN;
    end else if (point_count_i > COUNT_MAX) begin
      count_clamped = COUNT_MAX;
    end else begin
      count_clamped = point_count_i;
    end
  end

  // After a first point the accumulators still hold zero, so the run totals need no
  // special handling beyond the first-point selects below.
  always_comb begin
    run_o.max_abs     = max_new;
    run_o.l2_sum      = s2_first_q ? '0 : ssum_sat;
    run_o.part_sum    = {1'b0, fsq_q} + {1'b0, ssum_q};
    run_o.last_square = s2_sq_q;
    run_o.nbr_sum     = s2_first_q ? nss_q : nss_sat;
    run_o.count       = count_clamped;
  end

  assign run_push_o = s2_valid_q && s2_last_q && !run_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '0;
      ssum_q <= '0;
      fsq_q  <= '0;
      nss_q  <= '0;
    end else if (s2_valid_q && advance) begin
      if (s2_last_q) begin
        max_q  <= '0;
        ssum_q <= '0;
        fsq_q  <= '0;
        nss_q  <= '0;
      end else if (s2_first_q) begin
        max_q <= max_new;
        fsq_q <= s2_sq_q;
      end else begin
        max_q  <= max_new;
        ssum_q <= ssum_sat;
        nss_q  <= nss_sat;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/gen_fifo.sv]
// Short queue of finished-run records between the front end and the norm engine.
// Uses gen_pkg for the record type.
`default_nettype none

module gen_fifo
  import gen_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire gen_run_t wdata_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output gen_run_t      rdata_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gen_run_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[hdl/gen_divider.sv]
// Restoring divider, one quotient bit per cycle, for the norm engine.
// Self-contained; the quotient is valid in the cycle done_o is high and holds after.
`default_nettype none

module gen_divider #(
  parameter int unsigned NUM_W = 67,
  parameter int unsigned DEN_W = 18
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The numerator register doubles as the quotient shift register.
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quot_o  = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/gen_isqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle, for the norm engine.
// Self-contained; the root is the floor of the true square root of the radicand.
`default_nettype none

module gen_isqrt #(
  parameter int unsigned RAD_W = 82
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RAD_W-1:0] rad_i,
  output logic                  done_o,
  output logic [RAD_W/2-1:0]    root_o
);

  localparam int unsigned ROOT_LEN = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_LEN + 2;
  localparam int unsigned CNT_W    = $clog2(ROOT_LEN);

  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_LEN-1:0] root_q;
  logic [REM_W-1:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  // Before each step the partial remainder is below 2^ROOT_LEN, so its top two
  // bits can be dropped when the next pair of radicand bits comes down.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_LEN - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_LEN-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[hdl/gen_back.sv]
// Norm engine: turns one run record into the three norms and holds the result.
// Uses gen_pkg, gen_divider and gen_isqrt.
`default_nettype none

module gen_back
  import gen_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     run_empty_i,
  input  wire gen_run_t run_i,
  output logic          run_pop_o,
  input  wire logic     pop,
  output logic          empty,
  output gen_out_t      out_data_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV_L2  = 6'b000010,
    ST_DIV_W   = 6'b000100,
    ST_SQRT_W  = 6'b001000,
    ST_OUT     = 6'b010000,
    ST_SPARE   = 6'b100000
  } gen_state_e;

  gen_state_e state_q, state_d;

  logic [ABS_W-1:0]     max_q;
  logic [COUNT_W-1:0]   m_q;
  logic [A2_W-1:0]      a2_q;
  logic [ROOT_W-1:0]    l2_q;
  logic [ROOT_W-1:0]    w21_q;
  logic [PROD_W-1:0]    mcand_q;
  logic [COUNT_W-1:0]   mplier_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  gen_out_t             out_q;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic                 sqrt_start;
  logic [RAD_W-1:0]     sqrt_rad;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;
  logic                 take_run;
  logic                 slot_free;
  logic                 load_out;

  assign take_run  = (state_q == ST_IDLE) && !run_empty_i;
  assign run_pop_o = take_run;
  assign slot_free = !out_valid_q || pop;
  assign load_out  = (state_q == ST_OUT) && slot_free;

  // The L2 quotient is taken first; the W21 division then runs while the L2 root
  // is being found, since the two units are separate.
  assign div_start = take_run || ((state_q == ST_DIV_L2) && div_done);
  assign div_num   = take_run ? DIV_NUM_W'(run_i.l2_sum) : a2_q;
  assign div_den   = take_run ? {1'b0, run_i.count} : {m_q, 1'b0};

  assign sqrt_start = div_done && ((state_q == ST_DIV_L2) || (state_q == ST_DIV_W));
  assign sqrt_rad   = (state_q == ST_DIV_L2) ? RAD_W'(div_quot)
                                             : RAD_W'(PROD_W'(div_quot) + prod_q);

  gen_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  gen_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_run) begin
          state_d = ST_DIV_L2;
        end
      end
      ST_DIV_L2: begin
        if (div_done) begin
          state_d = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (div_done) begin
          state_d = ST_SQRT_W;
        end
      end
      ST_SQRT_W: begin
        if (sqrt_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The neighbour sum times M is formed by shift and add while the first division runs.
  always_ff @(posedge clk_i) begin
    if (take_run) begin
      max_q    <= run_i.max_abs;
      m_q      <= run_i.count;
      a2_q     <= A2_W'({run_i.part_sum, 1'b0}) + A2_W'(run_i.last_square);
      mcand_q  <= PROD_W'(run_i.nbr_sum);
      mplier_q <= run_i.count;
      prod_q   <= '0;
    end else if (mplier_q != '0) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[COUNT_W-1:1]};
    end
    if ((state_q == ST_DIV_W) && sqrt_done) begin
      l2_q <= sqrt_root;
    end
    if ((state_q == ST_SQRT_W) && sqrt_done) begin
      w21_q <= sqrt_root;
    end
    if (load_out) begin
      out_q.max_abs_error <= max_q;
      out_q.l2_error      <= NORM_W'(l2_q);
      out_q.w21_error     <= NORM_W'(w21_q);
    end
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule

`default_nettype wire

[hdl/grid_error_norms_unit.sv]
// Top level of the grid error norms block: point count register, front end,
// run queue and norm engine. Uses gen_pkg, gen_front, gen_fifo and gen_back.
//
//   Channel   Direction  Handshake                      Payload
//   samples   in         push / full, taken on !full     in_data_i  (gen_in_t)
//   norms     out        empty / pop, taken on !empty    out_data_o (gen_out_t)
//   config    in         cfg_we_i, no wait               cfg_wdata_i (point count)
//
// Samples are taken one per cycle while full is low; each passes a two-stage square
// pipeline before it reaches the run accumulators.
// A run record then waits in a queue of RUN_QUEUE_DEPTH entries; the norm engine
// works on one run at a time with its bit-serial divider (two quotients) and square
// root, and takes the next record only after the last result is loaded.
// full is raised only while a run's last point finds the record queue full.
// Reset clears the point count to 1024, all run totals, the run queue and the result slot at once.
`default_nettype none

module grid_error_norms_unit
  import gen_pkg::*;
#(
  parameter int unsigned RUN_QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire gen_in_t            in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output gen_out_t                out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i
);

  logic [COUNT_W-1:0] point_count_q;
  logic               run_push;
  logic               run_full;
  gen_run_t           run_in;
  logic               run_pop;
  logic               run_empty;
  gen_run_t           run_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  gen_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_data_i     (in_data_i),
    .point_count_i (point_count_q),
    .run_push_o    (run_push),
    .run_o         (run_in),
    .run_full_i    (run_full)
  );

  gen_fifo #(
    .DEPTH (RUN_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (run_push),
    .wdata_i (run_in),
    .full_o  (run_full),
    .pop_i   (run_pop),
    .rdata_o (run_out),
    .empty_o (run_empty)
  );

  gen_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_empty_i (run_empty),
    .run_i       (run_out),
    .run_pop_o   (run_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/gen_checker.sv]
// Port-level checks for grid_error_norms_unit, attached by the bind at the end.
// Uses gen_pkg for the payload types.
`default_nettype none

module gen_checker
  import gen_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     push,
  input wire logic     full,
  input wire gen_in_t  in_data_i,
  input wire logic     empty,
  input wire logic     pop,
  input wire gen_out_t out_data_o
);

  logic [7:0] pending_q;
  logic       run_in;
  logic       run_out;

  // Runs ended at the input minus results taken at the output.
  assign run_in  = push && !full && in_data_i.last_point;
  assign run_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (run_in && !run_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (run_out && !run_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_o))
    else $error("waiting result changed or vanished before transfer");

  a_result_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != '0)
    else $error("result offered without a finished run");

  a_full_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !$past(full) && !$past(full, 2) |-> $past(push && in_data_i.last_point, 2))
    else $error("input stalled without a last point in the pipeline");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.l2_error[NORM_W-1:ABS_W] == '0 &&
               out_data_o.w21_error[NORM_W-1:ROOT_W] == '0)
    else $error("norm exceeds its reachable range");

endmodule

bind grid_error_norms_unit gen_checker u_gen_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for grid_error_norms_unit: streams grid sample pairs,
// predicts the max, L2 and W21 error norms of each run and compares every norm result.
// Depends on gen_pkg and the RTL of the block; needs no other file.
module tb_top;
  import gen_pkg::*;

  typedef struct {
    gen_in_t  pair;
    bit       typed;
    gen_out_t norms;
  } grid_row_t;

  localparam gen_out_t NO_NORMS = '0;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned PHASE_SAMPLES = 180;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  gen_in_t            in_data_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  gen_out_t           out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;

  // Predictor state: one run in progress plus the point count register.
  logic [COUNT_W-1:0]         grid_points;
  logic signed [SAMPLE_W-1:0] prev_err;
  logic [ABS_W-1:0]           peak_err;
  logic [SUM_W-1:0]           lead_sq;
  logic [SUM_W-1:0]           inner_sq_sum;
  logic [SUM_W-1:0]           jump_sq_sum;
  bit                         run_open;

  gen_out_t    expected_norms[$];
  int unsigned mismatches = 0;
  int unsigned samples_taken = 0;
  int unsigned norms_checked = 0;
  int unsigned settings_used = 0;
  bit          no_gaps = 1'b0;

  // The last rows of the two zero-error runs and the one-point run of d = 1.0 at M = 1024 carry typed norms.
  grid_row_t directed_rows [20] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1, '{32'h0, 48'h0, 48'h0}},
    '{'{32'h0000_0000, 32'h0001_0000, 1'b1}, 1'b1, '{32'h0001_0000, 48'h0, 48'd1448}},
    '{'{32'h8000_0000, 32'h7FFF_FFFF, 1'b1}, 1'b0, NO_NORMS},
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}, 1'b0, NO_NORMS},
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h8000_0000, 1'b1}, 1'b0, NO_NORMS},
    '{'{32'h0001_0000, 32'h0003_0000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'hFFFF_0000, 32'h0000_8000, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h1234_5678, 32'h1234_5678, 1'b1}, 1'b0, NO_NORMS},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1, '{32'h0, 48'h0, 48'h0}},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}, 1'b0, NO_NORMS},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 1'b1}, 1'b0, NO_NORMS}
  };

  // Point-count settings for the random phases; the out-of-range ones get clamped.
  logic [COUNT_W-1:0] grid_settings [8] = '{
    17'd0, 17'd2, 17'd65536, 17'd131071, 17'd1, 17'd3, 17'd65535, 17'd100
  };

  grid_error_norms_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [SUM_W-1:0] add_clip(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  endfunction

  // Square of a sign-extended difference, clipped to the accumulator width.
  function automatic logic [SUM_W-1:0] clipped_square(logic [SAMPLE_W+1:0] v);
    logic [SAMPLE_W+1:0]   mag;
    logic [2*SAMPLE_W+3:0] prod;
    mag = v[SAMPLE_W+1] ? (~v + 1'b1) : v;
    prod = (2*SAMPLE_W+4)'(mag) * (2*SAMPLE_W+4)'(mag);
    return (prod >> SUM_W) != 0 ? {SUM_W{1'b1}} : prod[SUM_W-1:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [NORM_W-1:0] norm_clip(logic [63:0] root);
    return (root >> NORM_W) != 0 ? {NORM_W{1'b1}} : root[NORM_W-1:0];
  endfunction

  function automatic void clear_run();
    prev_err = '0;
    peak_err = '0;
    lead_sq = '0;
    inner_sq_sum = '0;
    jump_sq_sum = '0;
    run_open = 1'b0;
  endfunction

  // Folds one accepted sample pair into the run; returns 1 with the norms on a last point.
  function automatic bit predict_norms(input gen_in_t pair, output gen_out_t norms);
    logic [SAMPLE_W:0]          diff;
    logic signed [SAMPLE_W-1:0] err;
    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W+1:0]        jump;
    logic [SUM_W-1:0]           sq;
    logic [COUNT_W-1:0]         m;
    logic [127:0]               radicand;
    diff = {pair.second_value[SAMPLE_W-1], pair.second_value}
         - {pair.first_value[SAMPLE_W-1], pair.first_value};
    if (diff[SAMPLE_W] != diff[SAMPLE_W-1])
      err = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    else
      err = diff[SAMPLE_W-1:0];
    mag = err[SAMPLE_W-1] ? (~err + 1'b1) : err;
    if (!run_open || mag > peak_err) peak_err = mag;
    sq = clipped_square({{2{err[SAMPLE_W-1]}}, err});
    if (run_open) begin
      jump = {{2{err[SAMPLE_W-1]}}, err} - {{2{prev_err[SAMPLE_W-1]}}, prev_err};
      jump_sq_sum = add_clip(jump_sq_sum, clipped_square(jump));
    end
    norms = NO_NORMS;
    if (!pair.last_point) begin
      if (!run_open) lead_sq = sq;
      else inner_sq_sum = add_clip(inner_sq_sum, sq);
      run_open = 1'b1;
      prev_err = err;
      return 1'b0;
    end
    m = grid_points;
    if (m < COUNT_MIN) m = COUNT_MIN;
    if (m > COUNT_MAX) m = COUNT_MAX;
    norms.max_abs_error = peak_err;
    if (run_open)
      norms.l2_error = norm_clip(floor_sqrt(128'(add_clip(inner_sq_sum, sq)) / 128'(m)));
    else
      norms.l2_error = '0;
    // Twice the leading squares plus the last one, over 2M, then the neighbour term times M.
    radicand = 128'(lead_sq) + 128'(inner_sq_sum);
    radicand = (radicand << 1) + 128'(sq);
    radicand = radicand / (128'(m) << 1) + 128'(jump_sq_sum) * 128'(m);
    norms.w21_error = norm_clip(floor_sqrt(radicand));
    clear_run();
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] grid_value();
    case ($urandom_range(12))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom();
      default: return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  task automatic push_sample(gen_in_t pair, bit typed, gen_out_t typed_norms);
    gen_out_t norms;
    while (!no_gaps && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= pair;
    do @(posedge clk_i); while (full);
    samples_taken++;
    if (predict_norms(pair, norms)) expected_norms.push_back(typed ? typed_norms : norms);
  endtask

  task automatic send_run();
    int unsigned pick;
    int unsigned length;
    gen_in_t     pair;
    pick = $urandom_range(99);
    if (pick < 10) length = 1;
    else if (pick < 80) length = $urandom_range(12, 2);
    else if (pick < 95) length = $urandom_range(40, 13);
    else length = $urandom_range(120, 41);
    for (int unsigned k = 0; k < length; k++) begin
      pair.first_value = grid_value();
      if ($urandom_range(3) == 0)
        pair.second_value = grid_value();
      else
        pair.second_value = pair.first_value + (32'($urandom_range(32'h2_0000)) - 32'h1_0000);
      pair.last_point = (k == length - 1);
      push_sample(pair, 1'b0, NO_NORMS);
    end
  endtask

  // Waits until every run has produced its norms and the norm engine has gone quiet.
  task automatic settle_block();
    push <= 1'b0;
    while (expected_norms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid_points(logic [COUNT_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_points = value;
    settings_used++;
  endtask

  task automatic check_norms(gen_out_t got);
    gen_out_t want;
    norms_checked++;
    if (expected_norms.size() == 0) begin
      $display("%0t: norms transfer with nothing expected, got %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_norms.pop_front();
    if (got.max_abs_error !== want.max_abs_error) begin
      $display("%0t: max_abs_error expected %h got %h", $time, want.max_abs_error,
               got.max_abs_error);
      mismatches++;
    end
    if (got.l2_error !== want.l2_error) begin
      $display("%0t: l2_error expected %h got %h", $time, want.l2_error, got.l2_error);
      mismatches++;
    end
    if (got.w21_error !== want.w21_error) begin
      $display("%0t: w21_error expected %h got %h", $time, want.w21_error, got.w21_error);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_norms(out_data_o);
    pop <= rst_ni && (no_gaps || $urandom_range(99) >= 23);
  end

  initial begin
    int unsigned phase_start;
    grid_points = COUNT_RESET;
    clear_run();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_sample(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].norms);
    settle_block();

    for (int p = 0; p <= 8; p++) begin
      if (p < 8) set_grid_points(grid_settings[p]);
      else set_grid_points(COUNT_W'($urandom_range(65536, 2)));
      // One phase runs with both sides streaming back to back.
      no_gaps = (p == 4);
      phase_start = samples_taken;
      while (samples_taken - phase_start < PHASE_SAMPLES) send_run();
      settle_block();
    end

    $display("Ran %0d sample pairs and checked %0d norm results", samples_taken, norms_checked);
    $display("over %0d point-count settings, with %0d mismatches.", settings_used + 1,
             mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d norm results still expected.", expected_norms.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
